>>> hdl/irc_line_tokenizer_top_assert.svh
// assertion macros for the irc line tokenizer checker
`ifndef IRC_LINE_TOKENIZER_TOP_ASSERT_SVH
`define IRC_LINE_TOKENIZER_TOP_ASSERT_SVH

// clocked check, quiet while reset is high
`define IRCTOK_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// clocked check that also holds across reset
`define IRCTOK_ASSERT_ALWAYS(label, prop, msg) \
  label: assert property (@(posedge clk) prop) else $error(msg);

`endif

>>> hdl/irctok_pkg.sv
// shared types, constants and parse functions for the irc line tokenizer
package irctok_pkg;

  typedef enum logic [3:0] {
    PH_LINE   = 4'd0,
    PH_TKEY0  = 4'd1,
    PH_TKEY   = 4'd2,
    PH_TVAL   = 4'd3,
    PH_PRE    = 4'd4,
    PH_PFX    = 4'd5,
    PH_PRECMD = 4'd6,
    PH_CMD    = 4'd7,
    PH_PARAM0 = 4'd8,
    PH_MID    = 4'd9,
    PH_TRAIL  = 4'd10
  } phase_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_REPLAY,
    ST_FEED,
    ST_FIN_A,
    ST_FIN_B,
    ST_FLUSH
  } ctl_state_t;

  localparam logic [2:0] KIND_TKEY   = 3'd0;
  localparam logic [2:0] KIND_TVAL   = 3'd1;
  localparam logic [2:0] KIND_PREFIX = 3'd2;
  localparam logic [2:0] KIND_CMD    = 3'd3;
  localparam logic [2:0] KIND_MID    = 3'd4;
  localparam logic [2:0] KIND_TRAIL  = 3'd5;

  localparam logic [7:0] CH_AT     = 8'h40;
  localparam logic [7:0] CH_SEMI   = 8'h3B;
  localparam logic [7:0] CH_EQ     = 8'h3D;
  localparam logic [7:0] CH_COLON  = 8'h3A;
  localparam logic [7:0] CH_SPACE  = 8'h20;
  localparam logic [7:0] CH_BSLASH = 8'h5C;
  localparam logic [7:0] CH_LOW_S  = 8'h73;
  localparam logic [7:0] CH_LOW_R  = 8'h72;
  localparam logic [7:0] CH_LOW_N  = 8'h6E;
  localparam logic [7:0] CH_LOW_A  = 8'h61;
  localparam logic [7:0] CH_LOW_Z  = 8'h7A;
  localparam logic [7:0] CH_CR     = 8'h0D;
  localparam logic [7:0] CH_LF     = 8'h0A;
  localparam logic [7:0] CASE_GAP  = 8'h20;

  typedef struct packed {
    logic [7:0] byte_in;
    logic       byte_valid;
    logic       end_of_line;
  } in_item_t;

  typedef struct packed {
    logic [2:0] field_kind;
    logic [7:0] char_out;
    logic       char_valid;
    logic       field_start;
    logic       line_done;
    logic       pending_overflow;
  } out_item_t;

  typedef struct packed {
    phase_t phase;
    logic   esc;
    logic   open;
    logic   cmd_seen;
  } parse_state_t;

  localparam parse_state_t PST_RESET = '{phase: PH_LINE, esc: 1'b0, open: 1'b0,
                                         cmd_seen: 1'b0};

  typedef struct packed {
    logic       en;
    logic [2:0] kind;
    logic [7:0] ch;
    logic       valid;
    logic       start;
  } token_t;

  typedef struct packed {
    parse_state_t st;
    token_t       tok;
  } feed_result_t;

  typedef struct packed {
    logic latch;
    logic store_crlf;
    logic feed_replay;
    logic feed_main;
    logic fin_a;
    logic fin_b;
    logic flush;
  } ctrl_cmd_t;

  typedef struct packed {
    logic in_crlf;
    logic in_byte_valid;
    logic in_eol;
    logic store_empty;
    logic replay_last;
    logic step_eol;
    logic slot_free;
    logic out_free;
  } dp_status_t;

  function automatic logic [7:0] to_upper(input logic [7:0] c);
    return (c >= CH_LOW_A && c <= CH_LOW_Z) ? c - CASE_GAP : c;
  endfunction

  function automatic logic [7:0] unescape(input logic [7:0] c);
    logic [7:0] r;
    r = c;
    if (c == CH_COLON) r = CH_SEMI;
    else if (c == CH_LOW_S) r = CH_SPACE;
    else if (c == CH_LOW_R) r = CH_CR;
    else if (c == CH_LOW_N) r = CH_LF;
    return r;
  endfunction

  function automatic token_t tok_char(input logic [2:0] kind, input logic [7:0] ch,
                                      input logic open);
    return '{en: 1'b1, kind: kind, ch: ch, valid: 1'b1, start: ~open};
  endfunction

  function automatic token_t tok_mark(input logic [2:0] kind);
    return '{en: 1'b1, kind: kind, ch: 8'd0, valid: 1'b0, start: 1'b1};
  endfunction

  // one character through the parser: next state and at most one token
  function automatic feed_result_t feed_char(input parse_state_t s, input logic [7:0] c);
    feed_result_t r;
    phase_t       ph;
    r.st  = s;
    r.tok = '0;
    ph    = s.phase;
    if (ph == PH_LINE && c == CH_AT) begin
      r.st.phase = PH_TKEY0;
    end else begin
      if (ph == PH_LINE) ph = PH_PRE;
      r.st.phase = ph;
      case (ph)
        PH_TKEY0: begin
          if (c == CH_SEMI) begin
            r.st.phase = PH_TKEY0;
          end else if (c == CH_EQ) begin
            r.tok      = tok_mark(KIND_TKEY);
            r.st.open  = 1'b0;
            r.st.phase = PH_TVAL;
          end else if (c == CH_SPACE) begin
            r.st.phase = PH_PRE;
          end else begin
            r.tok      = tok_char(KIND_TKEY, c, 1'b0);
            r.st.open  = 1'b1;
            r.st.phase = PH_TKEY;
          end
        end
        PH_TKEY: begin
          if (c == CH_SEMI) begin
            r.tok      = tok_mark(KIND_TVAL);
            r.st.phase = PH_TKEY0;
          end else if (c == CH_EQ) begin
            r.st.open  = 1'b0;
            r.st.phase = PH_TVAL;
          end else if (c == CH_SPACE) begin
            r.tok      = tok_mark(KIND_TVAL);
            r.st.phase = PH_PRE;
          end else begin
            r.tok     = tok_char(KIND_TKEY, c, s.open);
            r.st.open = 1'b1;
          end
        end
        PH_TVAL: begin
          if (s.esc) begin
            r.st.esc  = 1'b0;
            r.st.open = 1'b1;
            if (c != CH_SEMI && c != CH_SPACE) begin
              r.tok = tok_char(KIND_TVAL, unescape(c), s.open);
            end else begin
              // lone backslash before a separator stays literal
              r.tok      = tok_char(KIND_TVAL, CH_BSLASH, s.open);
              r.st.phase = (c == CH_SEMI) ? PH_TKEY0 : PH_PRE;
            end
          end else if (c == CH_SEMI || c == CH_SPACE) begin
            if (!s.open) r.tok = tok_mark(KIND_TVAL);
            r.st.phase = (c == CH_SEMI) ? PH_TKEY0 : PH_PRE;
          end else if (c == CH_BSLASH) begin
            r.st.esc = 1'b1;
          end else begin
            r.tok     = tok_char(KIND_TVAL, c, s.open);
            r.st.open = 1'b1;
          end
        end
        PH_PRE: begin
          if (c == CH_SPACE) begin
            r.st.phase = PH_PRE;
          end else if (c == CH_COLON) begin
            r.st.open  = 1'b0;
            r.st.phase = PH_PFX;
          end else begin
            r.tok         = tok_char(KIND_CMD, to_upper(c), 1'b0);
            r.st.open     = 1'b1;
            r.st.cmd_seen = 1'b1;
            r.st.phase    = PH_CMD;
          end
        end
        PH_PFX: begin
          if (c == CH_SPACE) begin
            if (!s.open) r.tok = tok_mark(KIND_PREFIX);
            r.st.phase = PH_PRECMD;
          end else begin
            r.tok     = tok_char(KIND_PREFIX, c, s.open);
            r.st.open = 1'b1;
          end
        end
        PH_PRECMD: begin
          if (c != CH_SPACE) begin
            r.tok         = tok_char(KIND_CMD, to_upper(c), 1'b0);
            r.st.open     = 1'b1;
            r.st.cmd_seen = 1'b1;
            r.st.phase    = PH_CMD;
          end
        end
        PH_CMD: begin
          if (c == CH_SPACE) begin
            r.st.phase = PH_PARAM0;
          end else begin
            r.tok     = tok_char(KIND_CMD, to_upper(c), s.open);
            r.st.open = 1'b1;
          end
        end
        PH_PARAM0: begin
          if (c == CH_SPACE) begin
            r.st.phase = PH_PARAM0;
          end else if (c == CH_COLON) begin
            r.st.open  = 1'b0;
            r.st.phase = PH_TRAIL;
          end else begin
            r.tok      = tok_char(KIND_MID, c, 1'b0);
            r.st.open  = 1'b1;
            r.st.phase = PH_MID;
          end
        end
        PH_MID: begin
          if (c == CH_SPACE) begin
            r.st.phase = PH_PARAM0;
          end else begin
            r.tok     = tok_char(KIND_MID, c, s.open);
            r.st.open = 1'b1;
          end
        end
        default: begin
          r.tok      = tok_char(KIND_TRAIL, c, s.open);
          r.st.open  = 1'b1;
          r.st.phase = PH_TRAIL;
        end
      endcase
    end
    return r;
  endfunction

  // closing mark, or held backslash, of the field that is open at line end
  function automatic token_t finish_field(input parse_state_t s);
    token_t t;
    t = '0;
    case (s.phase)
      PH_TKEY: t = tok_mark(KIND_TVAL);
      PH_TVAL: begin
        if (s.esc) t = tok_char(KIND_TVAL, CH_BSLASH, s.open);
        else if (!s.open) t = tok_mark(KIND_TVAL);
      end
      PH_PFX:   if (!s.open) t = tok_mark(KIND_PREFIX);
      PH_TRAIL: if (!s.open) t = tok_mark(KIND_TRAIL);
      default:  t = '0;
    endcase
    return t;
  endfunction

  function automatic token_t finish_command(input parse_state_t s);
    return s.cmd_seen ? token_t'('0) : tok_mark(KIND_CMD);
  endfunction

endpackage

>>> hdl/irctok_ctrl.sv
// sequencing state machine: accept, replay, feed, finish and flush steps
module irctok_ctrl
  import irctok_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  output logic       in_ready,
  input  dp_status_t status,
  output ctrl_cmd_t  cmd
);

  ctl_state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    cmd        = '0;
    in_ready   = 1'b0;
    case (state)
      ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          if (status.in_crlf && !status.in_eol) begin
            cmd.store_crlf = 1'b1;
          end else begin
            cmd.latch = 1'b1;
            if (status.in_byte_valid && !status.in_crlf) begin
              state_next = status.store_empty ? ST_FEED : ST_REPLAY;
            end else if (status.in_eol) begin
              state_next = ST_FIN_A;
            end
          end
        end
      end
      ST_REPLAY: begin
        if (status.slot_free) begin
          cmd.feed_replay = 1'b1;
          if (status.replay_last) state_next = ST_FEED;
        end
      end
      ST_FEED: begin
        if (status.slot_free) begin
          cmd.feed_main = 1'b1;
          state_next    = status.step_eol ? ST_FIN_A : ST_FLUSH;
        end
      end
      ST_FIN_A: begin
        if (status.slot_free) begin
          cmd.fin_a  = 1'b1;
          state_next = ST_FIN_B;
        end
      end
      ST_FIN_B: begin
        if (status.slot_free) begin
          cmd.fin_b  = 1'b1;
          state_next = ST_FLUSH;
        end
      end
      ST_FLUSH: begin
        if (status.out_free) begin
          cmd.flush  = 1'b1;
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

endmodule

>>> hdl/irctok_dp.sv
// parser state, cr/lf store, one-beat hold stage and output register
module irctok_dp
  import irctok_pkg::*;
#(
  parameter int CRLF_DEPTH = 8
) (
  input  logic       clk,
  input  logic       rst,
  input  in_item_t   in_data,
  input  logic       out_ready,
  output logic       out_valid,
  output out_item_t  out_data,
  input  ctrl_cmd_t  cmd,
  output dp_status_t status
);

  localparam int CAP   = (CRLF_DEPTH < 1) ? 1 : ((CRLF_DEPTH > 9) ? 9 : CRLF_DEPTH);
  localparam int CNT_W = $clog2(CAP + 1);
  localparam int IDX_W = (CAP > 1) ? $clog2(CAP) : 1;

  parse_state_t   pst;
  logic [CAP-1:0] crlf_store;
  logic [CNT_W-1:0] crlf_count;
  logic           run_overflow;
  logic [7:0]     step_byte;
  logic           step_eol;
  logic           step_flag;
  logic           hold_valid;
  out_item_t      hold;
  out_item_t      out_r;

  logic         in_crlf;
  logic         in_plain;
  logic [7:0]   feed_byte;
  feed_result_t fr;
  token_t       tok;
  logic         work;
  logic         out_free;
  logic         slot_free;
  logic         out_load;
  out_item_t    new_item;

  assign in_crlf  = in_data.byte_valid &&
                    (in_data.byte_in == CH_CR || in_data.byte_in == CH_LF);
  assign in_plain = in_data.byte_valid && !in_crlf;

  // stored run replays oldest first from bit 0, lf held as one
  assign feed_byte = cmd.feed_replay ? (crlf_store[0] ? CH_LF : CH_CR) : step_byte;
  assign fr        = feed_char(pst, feed_byte);

  always_comb begin
    tok = '0;
    if (cmd.feed_replay || cmd.feed_main) tok = fr.tok;
    else if (cmd.fin_a) tok = finish_field(pst);
    else if (cmd.fin_b) tok = finish_command(pst);
  end

  assign work      = cmd.feed_replay || cmd.feed_main || cmd.fin_a || cmd.fin_b;
  assign out_free  = !out_valid || out_ready;
  assign slot_free = !hold_valid || out_free;
  assign out_load  = (work && tok.en && hold_valid) || (cmd.flush && (hold_valid || step_eol));

  assign new_item = '{field_kind: tok.kind, char_out: tok.ch, char_valid: tok.valid,
                      field_start: tok.start, line_done: 1'b0,
                      pending_overflow: step_flag};

  assign status = '{in_crlf: in_crlf, in_byte_valid: in_data.byte_valid,
                    in_eol: in_data.end_of_line, store_empty: (crlf_count == '0),
                    replay_last: (crlf_count == CNT_W'(1)), step_eol: step_eol,
                    slot_free: slot_free, out_free: out_free};

  always_ff @(posedge clk) begin
    if (rst) begin
      pst          <= PST_RESET;
      crlf_store   <= '0;
      crlf_count   <= '0;
      run_overflow <= 1'b0;
      step_eol     <= 1'b0;
      step_flag    <= 1'b0;
      hold_valid   <= 1'b0;
      out_valid    <= 1'b0;
    end else begin
      if (out_load) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end

      if (cmd.latch) begin
        step_byte <= in_data.byte_in;
        step_eol  <= in_data.end_of_line;
        step_flag <= in_plain && run_overflow;
        if (in_plain) run_overflow <= 1'b0;
      end

      if (cmd.store_crlf) begin
        if (crlf_count < CNT_W'(CAP)) begin
          crlf_store[crlf_count[IDX_W-1:0]] <= (in_data.byte_in == CH_LF);
          crlf_count <= crlf_count + CNT_W'(1);
        end else begin
          run_overflow <= 1'b1;
        end
      end

      if (cmd.feed_replay) begin
        crlf_store <= crlf_store >> 1;
        crlf_count <= crlf_count - CNT_W'(1);
      end

      if (cmd.feed_replay || cmd.feed_main) pst <= fr.st;

      // a new beat pushes the held one out, so the last beat can take line_done
      if (work && tok.en) begin
        if (hold_valid) begin
          out_r <= hold;
        end
        hold       <= new_item;
        hold_valid <= 1'b1;
      end

      if (cmd.flush) begin
        if (hold_valid) begin
          out_r <= '{field_kind: hold.field_kind, char_out: hold.char_out,
                     char_valid: hold.char_valid, field_start: hold.field_start,
                     line_done: step_eol, pending_overflow: hold.pending_overflow};
          hold_valid <= 1'b0;
        end else if (step_eol) begin
          out_r <= '{field_kind: KIND_TKEY, char_out: 8'd0, char_valid: 1'b0,
                     field_start: 1'b0, line_done: 1'b1, pending_overflow: step_flag};
        end
        if (step_eol) begin
          pst          <= PST_RESET;
          crlf_store   <= '0;
          crlf_count   <= '0;
          run_overflow <= 1'b0;
        end
      end
    end
  end

  assign out_data = out_r;

endmodule

>>> hdl/irc_line_tokenizer_top.sv
// irc line tokenizer: one byte in, zero or more field-tagged characters out
// a plain byte is latched, fed into the hold stage and moved to the output register
//   at flush; steps: replay per held cr/lf, feed, fin_a and fin_b at line end, flush;
//   other line ends go straight to fin_a; a new item is taken only in idle
// output stalls hold the sequencer once the hold stage and output register are full
// reset: synchronous, clears parser state, cr/lf store and both output stages
module irc_line_tokenizer_top
  import irctok_pkg::*;
#(
  parameter int CRLF_DEPTH = 8
) (
  input  logic      clk,
  input  logic      rst,
  input  logic      in_valid,
  output logic      in_ready,
  input  in_item_t  in_data,
  output logic      out_valid,
  input  logic      out_ready,
  output out_item_t out_data
);

  ctrl_cmd_t  cmd;
  dp_status_t status;

  irctok_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .status   (status),
    .cmd      (cmd)
  );

  irctok_dp #(
    .CRLF_DEPTH (CRLF_DEPTH)
  ) u_dp (
    .clk       (clk),
    .rst       (rst),
    .in_data   (in_data),
    .out_ready (out_ready),
    .out_valid (out_valid),
    .out_data  (out_data),
    .cmd       (cmd),
    .status    (status)
  );

endmodule

>>> hdl/irctok_checker.sv
// port-level checks for the irc line tokenizer, bound to the top level
`include "irc_line_tokenizer_top_assert.svh"

module irctok_checker
  import irctok_pkg::*;
(
  input logic      clk,
  input logic      rst,
  input logic      in_valid,
  input logic      in_ready,
  input in_item_t  in_data,
  input logic      out_valid,
  input logic      out_ready,
  input out_item_t out_data
);

  // stalled input beat must hold
  `IRCTOK_ASSERT(a_in_hold, in_valid && !in_ready |=> in_valid && $stable(in_data), "input beat changed while stalled")

  // stalled output beat must hold
  `IRCTOK_ASSERT(a_out_hold, out_valid && !out_ready |=> out_valid && $stable(out_data), "output beat changed while stalled")

  // nothing comes out right after reset
  `IRCTOK_ASSERT_ALWAYS(a_reset_quiet, rst |=> !out_valid, "output valid right after reset")

  // a mark beat either opens an empty field or is the bare line end
  `IRCTOK_ASSERT(a_mark_shape, out_valid && !out_data.char_valid |-> out_data.field_start || out_data.line_done, "mark beat neither field start nor line end")

  // marks carry no character
  `IRCTOK_ASSERT(a_mark_char, out_valid && !out_data.char_valid |-> out_data.char_out == 8'd0, "mark beat with a character")

endmodule

bind irc_line_tokenizer_top irctok_checker u_checker (
  .clk       (clk),
  .rst       (rst),
  .in_valid  (in_valid),
  .in_ready  (in_ready),
  .in_data   (in_data),
  .out_valid (out_valid),
  .out_ready (out_ready),
  .out_data  (out_data)
);

>>> bench/irc_line_tokenizer_checker.sv
// watches both channels of the irc line tokenizer, predicts each result and compares
`timescale 1ns / 1ps

module irc_line_tokenizer_checker
  import irctok_pkg::*;
#(
  parameter int CRLF_DEPTH = 8
) (
  input  logic      clk,
  input  logic      rst,
  input  logic      in_valid,
  input  logic      in_ready,
  input  in_item_t  in_data,
  input  logic      out_valid,
  input  logic      out_ready,
  input  out_item_t out_data,
  output int        errors,
  output int        outstanding
);

  localparam int HELD_CAP = (CRLF_DEPTH < 1) ? 1 : ((CRLF_DEPTH > 9) ? 9 : CRLF_DEPTH);
  localparam int MAX_PER_BEAT = 12;

  // tokenizer state as seen from outside
  phase_t              phase;
  logic                esc_held;
  logic                in_field;
  logic                cmd_seen;
  logic [HELD_CAP-1:0] held_lf;
  int                  held_count;
  logic                held_overflow;

  out_item_t beat_chars[$];
  out_item_t expected_chars[$];
  int        fail_count = 0;

  task automatic clear_state();
    phase         = PH_LINE;
    esc_held      = 1'b0;
    in_field      = 1'b0;
    cmd_seen      = 1'b0;
    held_lf       = '0;
    held_count    = 0;
    held_overflow = 1'b0;
  endtask

  function automatic logic [7:0] upcase(input logic [7:0] c);
    return (c >= CH_LOW_A && c <= CH_LOW_Z) ? (c & ~CASE_GAP) : c;
  endfunction

  function automatic logic [7:0] escape_value(input logic [7:0] c);
    case (c)
      CH_COLON: return CH_SEMI;
      CH_LOW_S: return CH_SPACE;
      CH_LOW_R: return CH_CR;
      CH_LOW_N: return CH_LF;
      default:  return c;
    endcase
  endfunction

  task automatic add_result(input logic [2:0] kind, input logic [7:0] ch, input logic valid,
                            input logic start);
    out_item_t r;
    r.field_kind       = kind;
    r.char_out         = ch;
    r.char_valid       = valid;
    r.field_start      = start;
    r.line_done        = 1'b0;
    r.pending_overflow = 1'b0;
    if (beat_chars.size() < MAX_PER_BEAT) beat_chars.push_back(r);
  endtask

  task automatic push_char(input logic [2:0] kind, input logic [7:0] ch);
    add_result(kind, ch, 1'b1, ~in_field);
    in_field = 1'b1;
  endtask

  task automatic push_mark(input logic [2:0] kind);
    add_result(kind, 8'd0, 1'b0, 1'b1);
  endtask

  task automatic begin_command(input logic [7:0] c);
    in_field = 1'b0;
    cmd_seen = 1'b1;
    push_char(KIND_CMD, upcase(c));
    phase = PH_CMD;
  endtask

  task automatic parse_char(input logic [7:0] c);
    if (phase == PH_LINE) begin
      if (c == CH_AT) begin
        phase = PH_TKEY0;
        return;
      end
      phase = PH_PRE;
    end
    case (phase)
      PH_TKEY0: begin
        if (c == CH_EQ) begin
          push_mark(KIND_TKEY);
          in_field = 1'b0;
          phase    = PH_TVAL;
        end else if (c == CH_SPACE) begin
          phase = PH_PRE;
        end else if (c != CH_SEMI) begin
          in_field = 1'b0;
          push_char(KIND_TKEY, c);
          phase = PH_TKEY;
        end
      end
      PH_TKEY: begin
        if (c == CH_SEMI) begin
          push_mark(KIND_TVAL);
          phase = PH_TKEY0;
        end else if (c == CH_EQ) begin
          in_field = 1'b0;
          phase    = PH_TVAL;
        end else if (c == CH_SPACE) begin
          push_mark(KIND_TVAL);
          phase = PH_PRE;
        end else begin
          push_char(KIND_TKEY, c);
        end
      end
      PH_TVAL: begin
        if (esc_held) begin
          esc_held = 1'b0;
          if (c != CH_SEMI && c != CH_SPACE) begin
            push_char(KIND_TVAL, escape_value(c));
            return;
          end
          // backslash right before a separator is kept as is
          push_char(KIND_TVAL, CH_BSLASH);
        end
        if (c == CH_SEMI || c == CH_SPACE) begin
          if (!in_field) push_mark(KIND_TVAL);
          phase = (c == CH_SEMI) ? PH_TKEY0 : PH_PRE;
        end else if (c == CH_BSLASH) begin
          esc_held = 1'b1;
        end else begin
          push_char(KIND_TVAL, c);
        end
      end
      PH_PRE: begin
        if (c == CH_COLON) begin
          in_field = 1'b0;
          phase    = PH_PFX;
        end else if (c != CH_SPACE) begin
          begin_command(c);
        end
      end
      PH_PFX: begin
        if (c == CH_SPACE) begin
          if (!in_field) push_mark(KIND_PREFIX);
          phase = PH_PRECMD;
        end else begin
          push_char(KIND_PREFIX, c);
        end
      end
      PH_PRECMD: begin
        if (c != CH_SPACE) begin_command(c);
      end
      PH_CMD: begin
        if (c == CH_SPACE) phase = PH_PARAM0;
        else push_char(KIND_CMD, upcase(c));
      end
      PH_PARAM0: begin
        if (c == CH_COLON) begin
          in_field = 1'b0;
          phase    = PH_TRAIL;
        end else if (c != CH_SPACE) begin
          in_field = 1'b0;
          push_char(KIND_MID, c);
          phase = PH_MID;
        end
      end
      PH_MID: begin
        if (c == CH_SPACE) phase = PH_PARAM0;
        else push_char(KIND_MID, c);
      end
      default: push_char(KIND_TRAIL, c);
    endcase
  endtask

  task automatic close_line();
    case (phase)
      PH_TKEY: push_mark(KIND_TVAL);
      PH_TVAL: begin
        if (esc_held) push_char(KIND_TVAL, CH_BSLASH);
        else if (!in_field) push_mark(KIND_TVAL);
      end
      PH_PFX:   if (!in_field) push_mark(KIND_PREFIX);
      PH_TRAIL: if (!in_field) push_mark(KIND_TRAIL);
      default: ;
    endcase
    if (!cmd_seen) push_mark(KIND_CMD);
    // a line end always says something
    if (beat_chars.size() == 0) add_result(KIND_TKEY, 8'd0, 1'b0, 1'b0);
    beat_chars[beat_chars.size()-1].line_done = 1'b1;
  endtask

  task automatic tokenize_item(input in_item_t it);
    logic is_crlf;
    logic ovf;
    int   i;
    beat_chars.delete();
    is_crlf = it.byte_valid && (it.byte_in == CH_CR || it.byte_in == CH_LF);
    ovf     = 1'b0;
    if (is_crlf && !it.end_of_line) begin
      if (held_count < HELD_CAP) begin
        held_lf[held_count] = (it.byte_in == CH_LF);
        held_count++;
      end else begin
        held_overflow = 1'b1;
      end
      return;
    end
    if (it.byte_valid && !is_crlf) begin
      ovf = held_overflow;
      for (i = 0; i < held_count; i++) parse_char(held_lf[i] ? CH_LF : CH_CR);
      held_lf       = '0;
      held_count    = 0;
      held_overflow = 1'b0;
      parse_char(it.byte_in);
    end
    if (it.end_of_line) begin
      close_line();
      clear_state();
    end
    foreach (beat_chars[k]) begin
      beat_chars[k].pending_overflow = ovf;
      expected_chars.push_back(beat_chars[k]);
    end
  endtask

  task automatic report_mismatch(input string msg);
    fail_count++;
    if (fail_count <= 30) $display("[%0t] tokenizer mismatch: %s", $time, msg);
  endtask

  task automatic check_result(input out_item_t got);
    out_item_t want;
    if (expected_chars.size() == 0) begin
      report_mismatch($sformatf("result %h with nothing expected", got));
      return;
    end
    want = expected_chars.pop_front();
    if (got.field_kind !== want.field_kind)
      report_mismatch($sformatf("field_kind got %0d want %0d", got.field_kind,
                                want.field_kind));
    if (got.char_out !== want.char_out)
      report_mismatch($sformatf("char_out got %h want %h", got.char_out, want.char_out));
    if (got.char_valid !== want.char_valid)
      report_mismatch($sformatf("char_valid got %b want %b", got.char_valid,
                                want.char_valid));
    if (got.field_start !== want.field_start)
      report_mismatch($sformatf("field_start got %b want %b", got.field_start,
                                want.field_start));
    if (got.line_done !== want.line_done)
      report_mismatch($sformatf("line_done got %b want %b", got.line_done, want.line_done));
    if (got.pending_overflow !== want.pending_overflow)
      report_mismatch($sformatf("pending_overflow got %b want %b", got.pending_overflow,
                                want.pending_overflow));
  endtask

  always @(posedge clk) begin
    if (rst) begin
      clear_state();
      expected_chars.delete();
    end else begin
      // results in this beat come from items accepted earlier
      if (out_valid && out_ready) check_result(out_data);
      if (in_valid && in_ready) tokenize_item(in_data);
    end
    errors      <= fail_count;
    outstanding <= expected_chars.size();
  end

endmodule

>>> bench/testbench.sv
// top-level bench for the irc line tokenizer: stimulus, handshake pacing and verdict
`timescale 1ns / 1ps

module testbench;
  import irctok_pkg::*;

  localparam int CRLF_DEPTH  = 8;
  localparam int CYCLE_LIMIT = 200000;
  localparam int ITEM_GOAL   = 270;

  typedef enum int {END_ON_BYTE, END_BARE, END_CRLF, END_CRLF_BARE} line_end_t;

  logic      clk;
  logic      rst;
  logic      in_valid;
  logic      in_ready;
  in_item_t  in_data;
  logic      out_valid;
  logic      out_ready;
  out_item_t out_data;
  int        errors;
  int        outstanding;
  int        cycles = 0;
  logic      hold_off_go;
  int        burst_left = 0;
  int        items_sent = 0;
  in_item_t  line_q[$];

  irc_line_tokenizer_top #(.CRLF_DEPTH(CRLF_DEPTH)) dut (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .in_data  (in_data),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .out_data (out_data)
  );

  irc_line_tokenizer_checker #(.CRLF_DEPTH(CRLF_DEPTH)) u_scoreboard (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .in_data    (in_data),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .out_data   (out_data),
    .errors     (errors),
    .outstanding(outstanding)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles == CYCLE_LIMIT) begin
      $display("Simulation FAILED");
      $finish;
    end
  end

  // receiver: segments of varying ready density, plus one long hold-off
  initial begin : sink_pacing
    int  seg_len;
    int  pct;
    bit  held;
    held = 1'b0;
    out_ready = 1'b0;
    while (rst !== 1'b0) @(posedge clk);
    forever begin
      if (hold_off_go && !held) begin
        held = 1'b1;
        out_ready <= 1'b0;
        repeat (150) @(posedge clk);
      end else begin
        seg_len = $urandom_range(8, 40);
        case ($urandom_range(4))
          0, 1:    pct = 100;
          2:       pct = 70;
          3:       pct = 40;
          default: pct = 15;
        endcase
        repeat (seg_len) begin
          out_ready <= ($urandom_range(99) < pct);
          @(posedge clk);
        end
      end
    end
  end

  task automatic send_item(input in_item_t it);
    int gap;
    if (burst_left == 0) begin
      gap = ($urandom_range(3) == 0) ? 0 : $urandom_range(1, 6);
      if (gap > 0) begin
        in_valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      burst_left = $urandom_range(1, 24);
    end
    burst_left--;
    in_data  <= it;
    in_valid <= 1'b1;
    do @(posedge clk); while (!in_ready);
    if (it.byte_valid || it.end_of_line) items_sent++;
  endtask

  task automatic add_byte(input logic [7:0] b);
    line_q.push_back('{byte_in: b, byte_valid: 1'b1, end_of_line: 1'b0});
  endtask

  task automatic add_text(input string s);
    foreach (s[i]) add_byte(s[i]);
  endtask

  // content byte, now and then preceded by an inner cr/lf run
  task automatic add_content(input logic [7:0] b);
    int n;
    if ($urandom_range(39) == 0) begin
      n = $urandom_range(1, 11);
      repeat (n) add_byte($urandom_range(1) ? CH_LF : CH_CR);
    end
    add_byte(b);
  endtask

  task automatic add_end(input line_end_t mode);
    case (mode)
      END_ON_BYTE: begin
        if (line_q.size() == 0)
          line_q.push_back('{byte_in: 8'd0, byte_valid: 1'b0, end_of_line: 1'b1});
        else
          line_q[line_q.size()-1].end_of_line = 1'b1;
      end
      END_BARE:
        line_q.push_back('{byte_in: 8'($urandom_range(255)), byte_valid: 1'b0,
                           end_of_line: 1'b1});
      END_CRLF: begin
        add_byte(CH_CR);
        line_q.push_back('{byte_in: CH_LF, byte_valid: 1'b1, end_of_line: 1'b1});
      end
      default: begin
        add_byte(CH_CR);
        add_byte(CH_LF);
        line_q.push_back('{byte_in: 8'd0, byte_valid: 1'b0, end_of_line: 1'b1});
      end
    endcase
  endtask

  task automatic send_line();
    foreach (line_q[i]) begin
      if ($urandom_range(24) == 0)
        send_item('{byte_in: 8'($urandom_range(255)), byte_valid: 1'b0,
                    end_of_line: 1'b0});
      send_item(line_q[i]);
    end
    line_q.delete();
  endtask

  function automatic logic [7:0] word_byte();
    int r;
    r = $urandom_range(61);
    if (r < 26) return 8'(CH_LOW_A + r);
    if (r < 52) return 8'(CH_LOW_A - CASE_GAP + (r - 26));
    return 8'(8'h30 + (r - 52));
  endfunction

  // any byte but space and cr/lf, mostly plain letters
  function automatic logic [7:0] text_byte();
    logic [7:0] b;
    int         r;
    r = $urandom_range(99);
    if (r < 60) return word_byte();
    if (r < 85) return 8'($urandom_range(8'h21, 8'h7E));
    b = 8'($urandom_range(255));
    if (b == CH_SPACE || b == CH_CR || b == CH_LF) b = 8'h00;
    return b;
  endfunction

  task automatic add_spaces();
    int n;
    n = $urandom_range(1, 3);
    repeat (n) add_byte(CH_SPACE);
  endtask

  task automatic add_tag_value();
    int n;
    n = $urandom_range(0, 4);
    repeat (n) begin
      if ($urandom_range(9) < 3) begin
        add_content(CH_BSLASH);
        case ($urandom_range(5))
          0:       add_byte(CH_COLON);
          1:       add_byte(CH_LOW_S);
          2:       add_byte(CH_BSLASH);
          3:       add_byte(CH_LOW_R);
          4:       add_byte(CH_LOW_N);
          default: add_byte(word_byte());
        endcase
      end else begin
        add_content(text_byte());
      end
    end
    if ($urandom_range(6) == 0) add_byte(CH_BSLASH);
  endtask

  task automatic add_tags();
    int n;
    int k;
    int len;
    add_byte(CH_AT);
    n = $urandom_range(1, 3);
    for (k = 0; k < n; k++) begin
      if (k > 0) add_byte(CH_SEMI);
      if ($urandom_range(5) == 0) continue;
      len = $urandom_range(0, 3);
      repeat (len) add_content(word_byte());
      if ($urandom_range(9) < 7) begin
        add_byte(CH_EQ);
        add_tag_value();
      end
    end
  endtask

  task automatic build_line();
    int n;
    int r;
    if ($urandom_range(9) == 0) begin
      // noise line: raw bytes, some of them not carrying a character
      n = $urandom_range(1, 12);
      repeat (n)
        line_q.push_back('{byte_in: 8'($urandom_range(255)),
                           byte_valid: ($urandom_range(4) != 0), end_of_line: 1'b0});
    end else begin
      if ($urandom_range(1)) begin
        add_tags();
        if ($urandom_range(7) != 0) add_spaces();
      end
      if ($urandom_range(9) < 4) begin
        add_byte(CH_COLON);
        n = $urandom_range(0, 6);
        repeat (n) add_content(text_byte());
        add_spaces();
      end
      if ($urandom_range(9) != 0) begin
        if ($urandom_range(9) < 7) begin
          n = $urandom_range(1, 6);
          repeat (n) add_content(8'(CH_LOW_A + $urandom_range(25) -
                                    ($urandom_range(1) ? CASE_GAP : 8'd0)));
        end else begin
          repeat (3) add_content(8'(8'h30 + $urandom_range(9)));
        end
        n = $urandom_range(0, 3);
        repeat (n) begin
          add_spaces();
          r = $urandom_range(1, 5);
          repeat (r) add_content(($urandom_range(3) == 0) ? text_byte() : word_byte());
        end
        if ($urandom_range(9) < 4) begin
          add_spaces();
          add_byte(CH_COLON);
          n = $urandom_range(0, 8);
          repeat (n) add_content(($urandom_range(5) == 0) ? CH_SPACE : text_byte());
        end
      end
    end
    r = $urandom_range(99);
    if (r < 60)      add_end(END_ON_BYTE);
    else if (r < 75) add_end(END_BARE);
    else if (r < 90) add_end(END_CRLF);
    else             add_end(END_CRLF_BARE);
  endtask

  initial begin : stimulus
    int i;
    rst         = 1'b1;
    in_valid    = 1'b0;
    in_data     = '0;
    hold_off_go = 1'b0;
    repeat (10) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // bare end on an empty line: only the missing command mark
    add_end(END_BARE);
    send_line();
    // nothing to do
    send_item('{byte_in: 8'hA5, byte_valid: 1'b0, end_of_line: 1'b0});
    // empty tag item, empty key, escaped space, backslash before space,
    // empty prefix at line end and no command
    add_text("@;=\\s;k=\\ :");
    add_end(END_ON_BYTE);
    send_line();
    // lower-case command, collapsed spaces, empty trailing
    add_text("a  :");
    add_end(END_ON_BYTE);
    send_line();
    // backslash as the last byte of the line
    add_text("@v=\\");
    add_end(END_ON_BYTE);
    send_line();
    // cr/lf run one longer than the store, replayed into the command
    for (i = 0; i < CRLF_DEPTH + 1; i++) add_byte(i[0] ? CH_LF : CH_CR);
    add_byte(8'hFF);
    add_end(END_ON_BYTE);
    send_line();

    hold_off_go <= 1'b1;
    while (items_sent < ITEM_GOAL) begin
      build_line();
      send_line();
    end
    in_valid <= 1'b0;

    @(posedge clk);
    @(posedge clk);
    while (outstanding != 0) @(posedge clk);
    repeat (20) @(posedge clk);
    if (errors == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule

>>> irc_line_tokenizer_top.f
+incdir+hdl
hdl/irctok_pkg.sv
hdl/irctok_ctrl.sv
hdl/irctok_dp.sv
hdl/irc_line_tokenizer_top.sv
hdl/irctok_checker.sv
bench/irc_line_tokenizer_checker.sv
bench/testbench.sv
